// ----- rtl/ppc_pkg.sv -----
// ============================================================================
// ppc_pkg: pursuit PID controller shared definitions
// Fixed point constants, register reset values and the CORDIC angle table.
// ============================================================================
package ppc_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int TABLE_LEN        = 24;
   localparam int SQRT_STEPS       = 17;
   localparam int NUM_REGS         = 7;

   localparam logic signed [23:0] HALF_PI_Q20   = 24'sd1647099;
   localparam logic signed [27:0] ANG_LIMIT     = 28'sd12868;
   localparam logic signed [16:0] SCALE_0P4_Q16 = 17'sd26214;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_KP_DIST  = 3'd0;
   localparam logic [2:0] REG_KI_DIST  = 3'd1;
   localparam logic [2:0] REG_KD_DIST  = 3'd2;
   localparam logic [2:0] REG_KP_HEAD  = 3'd3;
   localparam logic [2:0] REG_KI_HEAD  = 3'd4;
   localparam logic [2:0] REG_KD_HEAD  = 3'd5;
   localparam logic [2:0] REG_CATCH    = 3'd6;

   localparam logic [15:0] RST_KP_DIST = 16'd4137;
   localparam logic [15:0] RST_KI_DIST = 16'd82;
   localparam logic [15:0] RST_KD_DIST = 16'd41;
   localparam logic [15:0] RST_KP_HEAD = 16'd14336;
   localparam logic [15:0] RST_KI_HEAD = 16'd20;
   localparam logic [15:0] RST_KD_HEAD = 16'd2048;
   localparam logic [15:0] RST_CATCH   = 16'd4096;

   // atan(2^-i) in Q.20.
   function automatic logic signed [23:0] atan_q20(input logic [4:0] idx);
      logic signed [23:0] val;
      unique case (idx)
         5'd0:  val = 24'sd823550;
         5'd1:  val = 24'sd486170;
         5'd2:  val = 24'sd256879;
         5'd3:  val = 24'sd130396;
         5'd4:  val = 24'sd65451;
         5'd5:  val = 24'sd32757;
         5'd6:  val = 24'sd16383;
         5'd7:  val = 24'sd8192;
         5'd8:  val = 24'sd4096;
         5'd9:  val = 24'sd2048;
         5'd10: val = 24'sd1024;
         5'd11: val = 24'sd512;
         5'd12: val = 24'sd256;
         5'd13: val = 24'sd128;
         5'd14: val = 24'sd64;
         5'd15: val = 24'sd32;
         5'd16: val = 24'sd16;
         5'd17: val = 24'sd8;
         5'd18: val = 24'sd4;
         5'd19: val = 24'sd2;
         5'd20: val = 24'sd1;
         5'd21: val = 24'sd1;
         default: val = 24'sd0;
      endcase
      return val;
   endfunction

endpackage

// ----- rtl/pursuit_pid_controller_top.sv -----
// ============================================================================
// pursuit_pid_controller_top: distance and heading PID pursuit controller
// Bit-serial square root and CORDIC vectoring, then two PID laws evaluated
// on one shared 25x17 multiplier under a small sequencer.
// ============================================================================
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  req_    | in        | req_valid/req_stall| pursuer x, y, heading, target x, y
//  rsp_    | out       | rsp_valid/rsp_stall| linear_cmd, angular_cmd, caught
//  csr_    | in        | csr_valid/csr_ready| register index, 16-bit write data
//
// A beat passes through the accept state, squaring on the shared multiplier,
// an iteration phase in which the square root and the CORDIC advance step by
// step together until both are done, a preparation state, the PID products on
// the shared multiplier and the output state, which waits while the output
// register is still held by rsp_stall.
// Reset is synchronous and active high; it restores register defaults and
// clears the PID history. req_stall is high whenever a beat is in progress.
module pursuit_pid_controller_top
   import ppc_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [15:0]        req_pursuer_x,
   input  logic [15:0]        req_pursuer_y,
   input  logic signed [14:0] req_pursuer_heading,
   input  logic [15:0]        req_target_x,
   input  logic [15:0]        req_target_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_linear_cmd,
   output logic signed [14:0] rsp_angular_cmd,
   output logic               rsp_caught,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);

   // The iteration phase covers both the root and the CORDIC.
   localparam int ITER_LAST = ((CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS) - 1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SQ, ST_ITER, ST_PREP, ST_MUL, ST_FIN
   } state_type;

   // Where the registered product goes on the next cycle.
   typedef enum logic [2:0] {
      DST_NONE, DST_H, DST_D, DST_LLO, DST_LHI
   } dst_type;

   state_type state_ff;
   logic [4:0] step_ff;

   // Configuration registers.
   logic [15:0] kp_d_ff, ki_d_ff, kd_d_ff, kp_h_ff, ki_h_ff, kd_h_ff, catch_ff;

   // Captured beat.
   logic signed [16:0] dx_ff, dy_ff;
   logic signed [14:0] hd_ff;

   // Square root.
   logic [33:0] rad_ff;
   logic [18:0] rem_ff;
   logic [16:0] root_ff;

   // CORDIC.
   logic signed [20:0] cx_ff, cy_ff;
   logic signed [23:0] cz_ff;
   logic               zero_ff;

   // PID state and operands.
   logic [16:0]        last_d_ff;
   logic signed [15:0] last_h_ff;
   logic signed [23:0] dint_ff, hint_ff;
   logic [16:0]        dist_ff;
   logic signed [15:0] herr_ff;
   logic signed [17:0] dd_ff;
   logic signed [16:0] dh_ff;

   // Shared multiplier and accumulators.
   logic signed [24:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [41:0] mul_p;
   logic signed [41:0] prod_ff;
   dst_type            dst_ff, dst_in;
   logic signed [41:0] acc_d_ff, acc_h_ff;
   logic signed [57:0] acc_l_ff;

   // ---------------------------------------------------------------------
   // Combinational pieces
   // ---------------------------------------------------------------------
   logic signed [16:0] dx_in, dy_in;
   assign dx_in = $signed({1'b0, req_target_x}) - $signed({1'b0, req_pursuer_x});
   assign dy_in = $signed({1'b0, req_target_y}) - $signed({1'b0, req_pursuer_y});

   // Restoring square root, one result bit per step.
   logic [20:0] rem_sh, trial;
   logic        root_bit;
   assign rem_sh   = {rem_ff, rad_ff[33:32]};
   assign trial    = {2'b00, root_ff, 2'b01};
   assign root_bit = (rem_sh >= trial);

   // CORDIC vectoring step.
   logic signed [20:0] cxs, cys;
   logic signed [23:0] ang_step;
   assign cxs      = cx_ff >>> step_ff;
   assign cys      = cy_ff >>> step_ff;
   assign ang_step = atan_q20(step_ff);

   // Bearing rounded to Q3.12 and the heading error.
   logic signed [24:0] z_round;
   logic signed [15:0] bearing, herr_in;
   assign z_round = {cz_ff[23], cz_ff} + 25'sd128;
   assign bearing = zero_ff ? 16'sd0 : z_round[23:8];
   assign herr_in = bearing - {hd_ff[14], hd_ff};

   // Saturating integrals.
   logic signed [24:0] dint_sum, hint_sum;
   logic signed [23:0] dint_in, hint_in;
   assign dint_sum = {dint_ff[23], dint_ff} + $signed({8'd0, root_ff});
   assign hint_sum = {hint_ff[23], hint_ff} + {{9{herr_in[15]}}, herr_in};
   always_comb begin
      dint_in = dint_sum[23:0];
      if (dint_sum[24] != dint_sum[23]) begin
         dint_in = dint_sum[24] ? 24'sh800000 : 24'sh7FFFFF;
      end
      hint_in = hint_sum[23:0];
      if (hint_sum[24] != hint_sum[23]) begin
         hint_in = hint_sum[24] ? 24'sh800000 : 24'sh7FFFFF;
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      dst_in = DST_NONE;
      if (state_ff == ST_SQ) begin
         mul_a = (step_ff == 5'd0) ? 25'(dx_ff) : 25'(dy_ff);
         mul_b = (step_ff == 5'd0) ? dx_ff : dy_ff;
      end else if (state_ff == ST_MUL) begin
         case (step_ff)
            5'd0: begin
               mul_a = 25'(herr_ff); mul_b = $signed({1'b0, kp_h_ff}); dst_in = DST_H;
            end
            5'd1: begin
               mul_a = 25'(hint_ff); mul_b = $signed({1'b0, ki_h_ff}); dst_in = DST_H;
            end
            5'd2: begin
               mul_a = 25'(dh_ff); mul_b = $signed({1'b0, kd_h_ff}); dst_in = DST_H;
            end
            5'd3: begin
               mul_a = $signed({8'd0, dist_ff}); mul_b = $signed({1'b0, kp_d_ff});
               dst_in = DST_D;
            end
            5'd4: begin
               mul_a = 25'(dint_ff); mul_b = $signed({1'b0, ki_d_ff}); dst_in = DST_D;
            end
            5'd5: begin
               mul_a = 25'(dd_ff); mul_b = $signed({1'b0, kd_d_ff}); dst_in = DST_D;
            end
            5'd7: begin
               mul_a = $signed({1'b0, acc_d_ff[23:0]}); mul_b = SCALE_0P4_Q16;
               dst_in = DST_LLO;
            end
            5'd8: begin
               mul_a = 25'(acc_d_ff[41:24]); mul_b = SCALE_0P4_Q16; dst_in = DST_LHI;
            end
            default: begin
               dst_in = DST_NONE;
            end
         endcase
      end
   end
   assign mul_p = mul_a * mul_b;

   // Final scaling and saturation.
   logic signed [57:0] lin_sum;
   logic signed [27:0] lin_q, ang_q;
   logic signed [41:0] ang_sum;
   logic signed [15:0] lin_out;
   logic signed [14:0] ang_out;
   logic               caught_out;
   assign lin_sum = acc_l_ff + 58'sd536870912;
   assign lin_q   = lin_sum[57:30];
   assign ang_sum = acc_h_ff + 42'sd8192;
   assign ang_q   = ang_sum[41:14];
   always_comb begin
      if (lin_q > 28'sd32767) begin
         lin_out = 16'sd32767;
      end else if (lin_q < -28'sd32768) begin
         lin_out = -16'sd32768;
      end else begin
         lin_out = lin_q[15:0];
      end
      if (ang_q > ANG_LIMIT) begin
         ang_out = ANG_LIMIT[14:0];
      end else if (ang_q < -ANG_LIMIT) begin
         ang_out = 15'(-ANG_LIMIT);
      end else begin
         ang_out = ang_q[14:0];
      end
   end
   assign caught_out = (dist_ff != '0) && (dist_ff < {1'b0, catch_ff});

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_d_ff  <= RST_KP_DIST;
         ki_d_ff  <= RST_KI_DIST;
         kd_d_ff  <= RST_KD_DIST;
         kp_h_ff  <= RST_KP_HEAD;
         ki_h_ff  <= RST_KI_HEAD;
         kd_h_ff  <= RST_KD_HEAD;
         catch_ff <= RST_CATCH;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_KP_DIST: kp_d_ff  <= csr_data;
            REG_KI_DIST: ki_d_ff  <= csr_data;
            REG_KD_DIST: kd_d_ff  <= csr_data;
            REG_KP_HEAD: kp_h_ff  <= csr_data;
            REG_KI_HEAD: ki_h_ff  <= csr_data;
            REG_KD_HEAD: kd_h_ff  <= csr_data;
            REG_CATCH:   catch_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer and datapath registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      dst_ff  <= reset ? DST_NONE : dst_in;
      case (dst_ff)
         DST_H:   acc_h_ff <= acc_h_ff + prod_ff;
         DST_D:   acc_d_ff <= acc_d_ff + prod_ff;
         DST_LLO: acc_l_ff <= acc_l_ff + 58'(prod_ff);
         DST_LHI: acc_l_ff <= acc_l_ff + $signed({prod_ff[33:0], 24'd0});
         default: ;
      endcase

      if (reset) begin
         state_ff  <= ST_IDLE;
         step_ff   <= '0;
         rsp_valid <= 1'b0;
         last_d_ff <= '0;
         last_h_ff <= '0;
         dint_ff   <= '0;
         hint_ff   <= '0;
      end else begin
         // The output stage reloads the register itself when it finishes.
         if (rsp_valid && !rsp_stall && state_ff != ST_FIN) begin
            rsp_valid <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  dx_ff    <= dx_in;
                  dy_ff    <= dy_in;
                  hd_ff    <= req_pursuer_heading;
                  step_ff  <= '0;
                  state_ff <= ST_SQ;
               end
            end
            ST_SQ: begin
               // Squares come off the multiplier; the CORDIC is prerotated.
               if (step_ff == 5'd0) begin
                  zero_ff <= (dx_ff == '0) && (dy_ff == '0);
                  if (dx_ff < 0) begin
                     if (dy_ff >= 0) begin
                        cx_ff <= 21'(dy_ff);
                        cy_ff <= -21'(dx_ff);
                        cz_ff <= HALF_PI_Q20;
                     end else begin
                        cx_ff <= -21'(dy_ff);
                        cy_ff <= 21'(dx_ff);
                        cz_ff <= -HALF_PI_Q20;
                     end
                  end else begin
                     cx_ff <= 21'(dx_ff);
                     cy_ff <= 21'(dy_ff);
                     cz_ff <= '0;
                  end
                  step_ff <= 5'd1;
               end else if (step_ff == 5'd1) begin
                  rad_ff  <= prod_ff[33:0];
                  step_ff <= 5'd2;
               end else begin
                  rad_ff   <= rad_ff + prod_ff[33:0];
                  rem_ff   <= '0;
                  root_ff  <= '0;
                  step_ff  <= '0;
                  state_ff <= ST_ITER;
               end
            end
            ST_ITER: begin
               if (32'(step_ff) < SQRT_STEPS) begin
                  rad_ff <= {rad_ff[31:0], 2'b00};
                  if (root_bit) begin
                     rem_ff  <= 19'(rem_sh - trial);
                     root_ff <= {root_ff[15:0], 1'b1};
                  end else begin
                     rem_ff  <= rem_sh[18:0];
                     root_ff <= {root_ff[15:0], 1'b0};
                  end
               end
               if (32'(step_ff) < CORDIC_STEPS) begin
                  if (cy_ff >= 0) begin
                     cx_ff <= cx_ff + cys;
                     cy_ff <= cy_ff - cxs;
                     cz_ff <= cz_ff + ang_step;
                  end else begin
                     cx_ff <= cx_ff - cys;
                     cy_ff <= cy_ff + cxs;
                     cz_ff <= cz_ff - ang_step;
                  end
               end
               if (32'(step_ff) == ITER_LAST) begin
                  state_ff <= ST_PREP;
               end else begin
                  step_ff <= step_ff + 5'd1;
               end
            end
            ST_PREP: begin
               // Errors, integrals and differences for both laws.
               dist_ff   <= root_ff;
               herr_ff   <= herr_in;
               dint_ff   <= dint_in;
               hint_ff   <= hint_in;
               dd_ff     <= $signed({1'b0, root_ff}) - $signed({1'b0, last_d_ff});
               dh_ff     <= {herr_in[15], herr_in} - {last_h_ff[15], last_h_ff};
               last_d_ff <= root_ff;
               last_h_ff <= herr_in;
               acc_d_ff  <= '0;
               acc_h_ff  <= '0;
               acc_l_ff  <= '0;
               step_ff   <= '0;
               state_ff  <= ST_MUL;
            end
            ST_MUL: begin
               if (step_ff == 5'd9) begin
                  state_ff <= ST_FIN;
               end else begin
                  step_ff <= step_ff + 5'd1;
               end
            end
            ST_FIN: begin
               if (!rsp_valid || !rsp_stall) begin
                  rsp_valid       <= 1'b1;
                  rsp_linear_cmd  <= lin_out;
                  rsp_angular_cmd <= ang_out;
                  rsp_caught      <= caught_out;
                  state_ff        <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
